@@ hw/rtl/cbts_pkg.sv @@
// ----------------------------------------------------------------------------
// CAN bit timing search - shared constants
// Widths, register map and quanta lane layout for the timing search core.
// ----------------------------------------------------------------------------
package cbts_pkg;

   // Largest quanta count tried; counts go down in steps of two
   localparam int MAX_QUANTA = 24;
   // Lanes cover the counts MAX_QUANTA down to 4 (smaller counts fail anyway)
   localparam int NUM_LANES  = (MAX_QUANTA - 4) / 2 + 1;
   localparam int LANE_W     = $clog2(NUM_LANES);
   localparam int Q_W        = $clog2(MAX_QUANTA + 1);

   // Field widths
   localparam int CLOCK_W    = 32;
   localparam int RATE_W     = 20;
   localparam int PRESC_W    = 10;
   localparam int SEG1_W     = 4;
   localparam int SEG2_W     = 3;
   localparam int WORD_W     = 24;

   // Divider step counter width (one quotient bit per cycle)
   localparam int STEP_W     = $clog2(CLOCK_W);

   // Register map
   localparam int ADDR_W     = 3;
   localparam logic [ADDR_W-3:0] REG_CLOCK_HZ = '0;
   localparam logic [CLOCK_W-1:0] CLOCK_RESET = 32'd100000000;

   // Fixed synchronisation jump width field
   localparam logic [1:0] JUMP_WIDTH = 2'd3;

   // Quanta count handled by a lane
   function automatic logic [Q_W-1:0] lane_quanta(input int idx);
      return Q_W'(MAX_QUANTA - 2 * idx);
   endfunction

endpackage

@@ hw/rtl/can_bit_timing_search_core.sv @@
// ----------------------------------------------------------------------------
// CAN bit timing search core
// Derives the bus timing word (prescaler, phase segments) from a bit rate.
// ----------------------------------------------------------------------------
// Usage:
//  - Set clock_hz over the APB-style port (byte address 0); it resets to
//    100 MHz. Write it only while busy is low.
//  - Pulse start with req_bitrate while busy is low. busy rises on the next
//    cycle and stays high until the result is out.
//  - The result word appears on the rsp_ ports for exactly one cycle, marked
//    by rsp_valid. The receiver cannot stall it.
// Operation:
//  - A restoring divider produces one quotient bit a cycle for
//    clock_hz / bitrate, while eleven narrow remainder lanes test the even
//    quanta counts 24 down to 4 on the same bits. A pick state chooses the
//    count, then the same divider computes quotient / count, and a finish
//    state forms the word; a failure is reported from the pick state. A
//    new word may be started in the cycle rsp_valid is high.
// Reset: synchronous, clears the sequencer and rsp_valid and restores clock_hz.
// ----------------------------------------------------------------------------
module can_bit_timing_search_core (
   input  logic                          clock,
   input  logic                          reset,
   // Command channel
   input  logic                          start,
   output logic                          busy,
   input  logic [cbts_pkg::RATE_W-1:0]   req_bitrate,
   // Result channel
   output logic                          rsp_valid,
   output logic                          rsp_found,
   output logic [cbts_pkg::PRESC_W-1:0]  rsp_prescaler,
   output logic                          rsp_prescaler_overflow,
   output logic [cbts_pkg::SEG1_W-1:0]   rsp_phase_one,
   output logic [cbts_pkg::SEG2_W-1:0]   rsp_phase_two,
   output logic [cbts_pkg::WORD_W-1:0]   rsp_timing_word,
   // Configuration port
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [cbts_pkg::ADDR_W-1:0]   paddr,
   input  logic [31:0]                   pwdata,
   output logic [31:0]                   prdata,
   output logic                          pready
);
   import cbts_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV_RATE,
      ST_PICK,
      ST_DIV_QUANTA,
      ST_FINISH
   } state_type;

   state_type              state_ff, state_in;
   logic [CLOCK_W-1:0]     clock_hz_ff, clock_hz_in;
   logic [CLOCK_W-1:0]     dvd_ff, dvd_in;
   logic [RATE_W-1:0]      dsr_ff, dsr_in;
   logic [RATE_W-1:0]      rem_ff, rem_in;
   logic [STEP_W-1:0]      cnt_ff, cnt_in;
   logic                   rate_zero_ff, rate_zero_in;
   logic [SEG1_W-1:0]      seg1_ff, seg1_in;
   logic [SEG2_W-1:0]      seg2_ff, seg2_in;
   logic [Q_W-1:0]         lane_rem_ff [NUM_LANES];
   logic [Q_W-1:0]         lane_rem_in [NUM_LANES];

   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_found_ff, rsp_found_in;
   logic [PRESC_W-1:0]     rsp_presc_ff, rsp_presc_in;
   logic                   rsp_ovf_ff, rsp_ovf_in;
   logic [SEG1_W-1:0]      rsp_seg1_ff, rsp_seg1_in;
   logic [SEG2_W-1:0]      rsp_seg2_ff, rsp_seg2_in;

   // Divider step signals
   logic [RATE_W:0]        partial;
   logic                   qbit;
   logic [RATE_W:0]        diff;

   // Lane selection
   logic [SEG1_W-1:0]      lane_seg1 [NUM_LANES];
   logic [SEG2_W-1:0]      lane_seg2 [NUM_LANES];
   logic                   pick_hit;
   logic [LANE_W-1:0]      pick_idx;
   logic                   pick_ok;

   logic [CLOCK_W-1:0]     presc_full;
   logic                   cfg_write;

   // Configuration access
   assign pready    = 1'b1;
   assign cfg_write = psel && penable && pwrite &&
                      (paddr[ADDR_W-1:2] == REG_CLOCK_HZ);
   assign prdata    = (paddr[ADDR_W-1:2] == REG_CLOCK_HZ) ? clock_hz_ff : '0;

   // One restoring division step: bring in the next dividend bit
   assign partial = {rem_ff, dvd_ff[CLOCK_W-1]};
   assign qbit    = (partial >= {1'b0, dsr_ff});
   assign diff    = partial - {1'b0, dsr_ff};

   // Per-lane remainder of the quotient modulo the lane's quanta count,
   // fed with the quotient bits as the first division produces them
   for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
      localparam int LQ = MAX_QUANTA - 2 * g;
      localparam int LN = LQ - 1;
      localparam logic [Q_W-1:0] LANE_Q = lane_quanta(g);
      logic [Q_W:0] lane_part;

      assign lane_seg1[g] = SEG1_W'(LN - LN / 3 - 1);
      assign lane_seg2[g] = SEG2_W'(LN / 3 - 1);
      assign lane_part    = {lane_rem_ff[g], qbit};

      always_comb begin
         lane_rem_in[g] = lane_rem_ff[g];
         if (state_ff == ST_IDLE) begin
            lane_rem_in[g] = '0;
         end else if (state_ff == ST_DIV_RATE) begin
            if (lane_part >= {1'b0, LANE_Q}) begin
               lane_rem_in[g] = Q_W'(lane_part - {1'b0, LANE_Q});
            end else begin
               lane_rem_in[g] = lane_part[Q_W-1:0];
            end
         end
      end
   end

   // Largest count whose lane leaves no remainder
   always_comb begin
      pick_hit = 1'b0;
      pick_idx = '0;
      for (int i = NUM_LANES - 1; i >= 0; i--) begin
         if (lane_rem_ff[i] == '0) begin
            pick_hit = 1'b1;
            pick_idx = LANE_W'(i);
         end
      end
   end

   assign pick_ok    = pick_hit && !rate_zero_ff && (|dvd_ff);
   assign presc_full = dvd_ff - CLOCK_W'(1);

   // Sequencer and datapath next state
   always_comb begin
      state_in      = state_ff;
      clock_hz_in   = clock_hz_ff;
      dvd_in        = dvd_ff;
      dsr_in        = dsr_ff;
      rem_in        = rem_ff;
      cnt_in        = cnt_ff;
      rate_zero_in  = rate_zero_ff;
      seg1_in       = seg1_ff;
      seg2_in       = seg2_ff;
      rsp_valid_in  = 1'b0;
      rsp_found_in  = rsp_found_ff;
      rsp_presc_in  = rsp_presc_ff;
      rsp_ovf_in    = rsp_ovf_ff;
      rsp_seg1_in   = rsp_seg1_ff;
      rsp_seg2_in   = rsp_seg2_ff;

      if (cfg_write) begin
         clock_hz_in = pwdata;
      end

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               dvd_in       = clock_hz_ff;
               dsr_in       = req_bitrate;
               rem_in       = '0;
               cnt_in       = '0;
               rate_zero_in = (req_bitrate == '0);
               state_in     = ST_DIV_RATE;
            end
         end
         ST_DIV_RATE, ST_DIV_QUANTA: begin
            dvd_in = {dvd_ff[CLOCK_W-2:0], qbit};
            rem_in = qbit ? diff[RATE_W-1:0] : partial[RATE_W-1:0];
            cnt_in = cnt_ff + STEP_W'(1);
            if (cnt_ff == STEP_W'(CLOCK_W - 1)) begin
               state_in = (state_ff == ST_DIV_RATE) ? ST_PICK : ST_FINISH;
            end
         end
         ST_PICK: begin
            if (pick_ok) begin
               dsr_in   = RATE_W'(lane_quanta(int'(pick_idx)));
               rem_in   = '0;
               cnt_in   = '0;
               seg1_in  = lane_seg1[pick_idx];
               seg2_in  = lane_seg2[pick_idx];
               state_in = ST_DIV_QUANTA;
            end else begin
               rsp_valid_in = 1'b1;
               rsp_found_in = 1'b0;
               rsp_presc_in = '0;
               rsp_ovf_in   = 1'b0;
               rsp_seg1_in  = '0;
               rsp_seg2_in  = '0;
               state_in     = ST_IDLE;
            end
         end
         ST_FINISH: begin
            rsp_valid_in = 1'b1;
            rsp_found_in = 1'b1;
            rsp_presc_in = presc_full[PRESC_W-1:0];
            rsp_ovf_in   = |presc_full[CLOCK_W-1:PRESC_W];
            rsp_seg1_in  = seg1_ff;
            rsp_seg2_in  = seg2_ff;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State, registers and result word
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         clock_hz_ff  <= CLOCK_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clock_hz_ff  <= clock_hz_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      dvd_ff       <= dvd_in;
      dsr_ff       <= dsr_in;
      rem_ff       <= rem_in;
      cnt_ff       <= cnt_in;
      rate_zero_ff <= rate_zero_in;
      seg1_ff      <= seg1_in;
      seg2_ff      <= seg2_in;
      rsp_found_ff <= rsp_found_in;
      rsp_presc_ff <= rsp_presc_in;
      rsp_ovf_ff   <= rsp_ovf_in;
      rsp_seg1_ff  <= rsp_seg1_in;
      rsp_seg2_ff  <= rsp_seg2_in;
      for (int i = 0; i < NUM_LANES; i++) begin
         lane_rem_ff[i] <= lane_rem_in[i];
      end
   end

   // Outputs
   assign busy                   = (state_ff != ST_IDLE);
   assign rsp_valid              = rsp_valid_ff;
   assign rsp_found              = rsp_found_ff;
   assign rsp_prescaler          = rsp_presc_ff;
   assign rsp_prescaler_overflow = rsp_ovf_ff;
   assign rsp_phase_one          = rsp_seg1_ff;
   assign rsp_phase_two          = rsp_seg2_ff;
   // Failure words carry zero segments and prescaler, so only the jump width
   // field needs gating
   assign rsp_timing_word = {1'b0, rsp_seg2_ff, rsp_seg1_ff,
                             rsp_found_ff ? JUMP_WIDTH : 2'b00,
                             4'b0000, rsp_presc_ff};

   // Checks
   a_busy_after_start: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("busy not raised after start");

   a_valid_when_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("word delivered while still busy");

   a_fail_word_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |-> rsp_timing_word == '0 && !rsp_prescaler_overflow)
      else $error("failure word not cleared");

   a_pick_only_after_div: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_PICK |-> $past(state_ff) == ST_DIV_RATE)
      else $error("pick entered out of sequence");

endmodule
